@@ hdl/hnd_pkg.sv @@
// Shared constants, types and helpers of the Hamming descriptor matcher.
package hnd_pkg;

  localparam int MaxEntries  = 1024;
  localparam int MaxWords    = 8;
  localparam int MaxTies     = 64;
  localparam int RowW        = $clog2(MaxEntries);
  localparam int CntW        = $clog2(MaxEntries + 1);
  localparam int PosW        = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int NwW         = $clog2(MaxWords + 1);
  localparam int TieIdxW     = (MaxTies > 1) ? $clog2(MaxTies) : 1;
  localparam int TieW        = $clog2(MaxTies + 1);
  localparam int DistW       = 9;
  localparam int ThrW        = 10;
  localparam int TolW        = 5;
  localparam int DrainCycles = 2 * MaxWords + 4;
  localparam int DrainW      = $clog2(DrainCycles + 1);

  typedef enum logic [1:0] {
    ACT_TRAIN = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TOLERANCE = 2'd1,
    REG_WORDS     = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // One candidate row moving down the cell chain.
  typedef struct packed {
    logic             valid;
    logic [RowW-1:0]  row;
    logic [DistW-1:0] sum;
  } flow_t;

  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) begin
      c = c + {5'd0, x[i]};
    end
    return c;
  endfunction

endpackage

@@ hdl/hamming_nearest_descriptor_match.sv @@
// Top level: word intake, scan sequencer, cell chain and result output.
//
//   port group        dir  timing
//   start/busy + item in   taken when start is high and busy is low
//   cfg_we/idx/data   in   written on any edge with cfg_we high
//   match_valid + res out  one cycle per result, cannot be held off
//
// A train word or a non-final query word is taken without raising busy. The final
// query word scans every stored entry, one row per cycle through a chain of eight
// lane cells; busy stays high through the scan, the chain drain and the results.
// Reset is synchronous and empties the table; stored words are not cleared.
module hamming_nearest_descriptor_match (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 action,
  input  logic [31:0]                word_data,
  input  logic [3:0]                 octave,
  input  logic [15:0]                query_id,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [hnd_pkg::ThrW-1:0]   cfg_data,
  output logic                       match_valid,
  output logic [15:0]                query_index,
  output logic [hnd_pkg::RowW-1:0]   train_row,
  output logic [hnd_pkg::DistW-1:0]  distance,
  output logic                       last_match,
  output logic                       ties_truncated
);
  import hnd_pkg::*;

  state_t state, state_next;

  logic [ThrW-1:0]  threshold;
  logic [TolW-1:0]  octave_tolerance;
  logic [3:0]       descriptor_words;
  logic [NwW-1:0]   nw;
  logic [PosW-1:0]  word_position;
  logic [PosW-1:0]  pos;
  logic             last;
  logic [CntW-1:0]  entry_count;
  logic [3:0]       query_octave;
  logic [15:0]      qid;
  logic [3:0]       octaves [MaxEntries];

  logic             accept;
  logic             train_we;
  logic             scan_clear;
  logic [CntW-1:0]  scan_row;
  logic             issue;
  logic [DrainW-1:0] drain_cnt;
  logic [TieIdxW-1:0] emit_k;
  logic             emit_go;
  logic             emit_last;

  logic             f_valid;
  logic [RowW-1:0]  f_row;
  logic [3:0]       f_oct;
  logic [3:0]       oct_diff;
  logic             oct_pass;

  flow_t            chain [MaxWords+1];

  logic [RowW-1:0]  tie_row;
  logic             found;
  logic [DistW-1:0] best;
  logic [TieW-1:0]  tie_count;
  logic             overflow;
  logic [ThrW-1:0]  thr;

  // Word count clamped to the supported range.
  always_comb begin
    if (descriptor_words == 4'd0) begin
      nw = NwW'(1);
    end else if (descriptor_words > 4'(MaxWords)) begin
      nw = NwW'(MaxWords);
    end else begin
      nw = NwW'(descriptor_words);
    end
  end

  assign pos  = ({1'b0, word_position} >= (NwW+1)'(nw)) ?
                PosW'(nw - 1'b1) : word_position;
  assign last = ((NwW+1)'(pos) + 1'b1 >= (NwW+1)'(nw));

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign train_we = accept && action == ACT_TRAIN && entry_count < CntW'(MaxEntries);
  assign scan_clear = accept && action == ACT_QUERY && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= '1;
      octave_tolerance <= '1;
      descriptor_words <= 4'(MaxWords);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold        <= cfg_data;
        REG_TOLERANCE: octave_tolerance <= cfg_data[TolW-1:0];
        REG_WORDS:     descriptor_words <= cfg_data[3:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      entry_count   <= '0;
      query_octave  <= '0;
    end else if (accept) begin
      case (action_t'(action))
        ACT_TRAIN: begin
          word_position <= last ? '0 : pos + 1'b1;
          if (train_we && last) begin
            entry_count <= entry_count + 1'b1;
          end
        end
        ACT_QUERY: begin
          word_position <= last ? '0 : pos + 1'b1;
          if (pos == '0) begin
            query_octave <= octave;
          end
        end
        ACT_CLEAR: begin
          word_position <= '0;
          entry_count   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (train_we && pos == '0) begin
      octaves[entry_count[RowW-1:0]] <= octave;
    end
    f_oct <= octaves[scan_row[RowW-1:0]];
    f_row <= scan_row[RowW-1:0];
    if (scan_clear) begin
      qid <= query_id;
    end
  end

  assign issue = (state == ST_SCAN) && scan_row < entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= issue;
    end
  end

  assign oct_diff = (f_oct >= query_octave) ? f_oct - query_octave : query_octave - f_oct;
  assign oct_pass = octave_tolerance[TolW-1] || oct_diff <= octave_tolerance[3:0];

  assign chain[0].valid = f_valid && oct_pass;
  assign chain[0].row   = f_row;
  assign chain[0].sum   = '0;

  for (genvar g = 0; g < MaxWords; g++) begin : g_cell
    hnd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (train_we && pos == PosW'(g)),
      .wr_addr  (entry_count[RowW-1:0]),
      .wr_data  (word_data),
      .q_en     (accept && action == ACT_QUERY && pos == PosW'(g)),
      .q_data   (word_data),
      .lane_on  (NwW'(g) < nw),
      .in_flow  (chain[g]),
      .out_flow (chain[g+1])
    );
  end

  hnd_ties u_ties (
    .clk       (clk),
    .rst       (rst),
    .clear     (scan_clear),
    .cand      (chain[MaxWords]),
    .rd_addr   (emit_k),
    .rd_row    (tie_row),
    .found     (found),
    .best      (best),
    .tie_count (tie_count),
    .overflow  (overflow)
  );

  // A negative threshold means twice the word count.
  assign thr = threshold[ThrW-1] ? ThrW'({nw, 1'b0}) : threshold;

  assign emit_last = ({1'b0, emit_k} + 1'b1 == tie_count);

  always_comb begin
    state_next = state;
    emit_go    = 1'b0;
    case (state)
      ST_IDLE:  if (scan_clear) state_next = ST_SCAN;
      ST_SCAN:  if (!issue) state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (drain_cnt == DrainW'(DrainCycles)) begin
          state_next = (found && {1'b0, best} <= thr) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        emit_go = 1'b1;
        if (emit_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_row  <= '0;
      drain_cnt <= '0;
      emit_k    <= '0;
    end else begin
      state <= state_next;
      if (scan_clear) begin
        scan_row <= '0;
      end else if (issue) begin
        scan_row <= scan_row + 1'b1;
      end
      drain_cnt <= (state == ST_DRAIN) ? drain_cnt + 1'b1 : '0;
      emit_k    <= emit_go ? emit_k + 1'b1 : '0;
    end
  end

  // The tie row read issued in EMIT arrives in the following cycle, with its fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else begin
      match_valid <= emit_go;
    end
    query_index    <= qid;
    distance       <= best;
    last_match     <= emit_last;
    ties_truncated <= overflow;
  end

  assign train_row = tie_row;

  a_strobe_after_emit: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> $past(state == ST_EMIT))
    else $error("result strobe without an emit cycle");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (match_valid && last_match) |=> !match_valid)
    else $error("result after the final result of a query");

  a_chain_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    chain[MaxWords].valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("candidate left the chain outside a scan");

  a_emit_has_ties: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (found && tie_count != '0))
    else $error("emitting with no stored tie");

endmodule

@@ hdl/hnd_cell.sv @@
// One lane of the matching chain: a train word column, a query word and a popcount adder.
module hnd_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [hnd_pkg::RowW-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     q_en,
  input  logic [31:0]              q_data,
  input  logic                     lane_on,
  input  hnd_pkg::flow_t           in_flow,
  output hnd_pkg::flow_t           out_flow
);
  import hnd_pkg::*;

  logic [31:0] words [MaxEntries];
  logic [31:0] qword;
  logic [31:0] rdata;
  flow_t       a_flow;
  logic [5:0]  pc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr] <= wr_data;
    end
    rdata <= words[in_flow.row];
    if (q_en) begin
      qword <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_flow.valid   <= 1'b0;
      out_flow.valid <= 1'b0;
    end else begin
      a_flow.valid   <= in_flow.valid;
      out_flow.valid <= a_flow.valid;
    end
    a_flow.row   <= in_flow.row;
    a_flow.sum   <= in_flow.sum;
    out_flow.row <= a_flow.row;
    out_flow.sum <= a_flow.sum + (lane_on ? {{(DistW-6){1'b0}}, pc} : '0);
  end

  assign pc = popcount32(rdata ^ qword);

endmodule

@@ hdl/hnd_ties.sv @@
// Tracks the minimum distance of a scan and keeps the rows found at it.
module hnd_ties (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  hnd_pkg::flow_t              cand,
  input  logic [hnd_pkg::TieIdxW-1:0] rd_addr,
  output logic [hnd_pkg::RowW-1:0]    rd_row,
  output logic                        found,
  output logic [hnd_pkg::DistW-1:0]   best,
  output logic [hnd_pkg::TieW-1:0]    tie_count,
  output logic                        overflow
);
  import hnd_pkg::*;

  logic [RowW-1:0] rows [MaxTies];
  logic            new_best;
  logic            wr_en;
  logic [TieIdxW-1:0] wr_addr;

  assign new_best = cand.valid && (!found || cand.sum < best);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = tie_count[TieIdxW-1:0];
    if (new_best) begin
      wr_en   = 1'b1;
      wr_addr = '0;
    end else if (cand.valid && cand.sum == best && tie_count < TieW'(MaxTies)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr] <= cand.row;
    end
    rd_row <= rows[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found     <= 1'b0;
      best      <= '1;
      tie_count <= '0;
      overflow  <= 1'b0;
    end else if (new_best) begin
      found     <= 1'b1;
      best      <= cand.sum;
      tie_count <= TieW'(1);
      overflow  <= 1'b0;
    end else if (cand.valid && cand.sum == best) begin
      if (tie_count < TieW'(MaxTies)) begin
        tie_count <= tie_count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the Hamming nearest-descriptor matcher.
module tb;
  import hnd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] qidx;
    logic [9:0]  row;
    logic [8:0]  hdist;
    logic        last;
    logic        trunc;
  } match_t;

  class match_board;
    match_t pending[$];
    int     errors;
    int     reported;

    function void note(match_t m);
      pending.push_back(m);
    endfunction

    function void check(match_t got);
      match_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected match row %0d dist %0d", got.row, got.hdist);
        end
        return;
      end
      exp = pending.pop_front();
      if (exp.qidx !== got.qidx || exp.row !== got.row || exp.hdist !== got.hdist ||
          exp.last !== got.last || exp.trunc !== got.trunc) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: exp q=%0d r=%0d d=%0d l=%0b t=%0b got q=%0d r=%0d d=%0d l=%0b t=%0b",
                   exp.qidx, exp.row, exp.hdist, exp.last, exp.trunc,
                   got.qidx, got.row, got.hdist, got.last, got.trunc);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = ACT_NONE;
  logic [31:0] word_data = '0;
  logic [3:0] octave = '0;
  logic [15:0] query_id = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_UNUSED;
  logic [ThrW-1:0] cfg_data = '0;
  logic match_valid;
  logic [15:0] query_index;
  logic [RowW-1:0] train_row;
  logic [DistW-1:0] distance;
  logic last_match;
  logic ties_truncated;

  hamming_nearest_descriptor_match u_dut (.*);

  always #10 clk = ~clk;

  match_board board = new();

  // Predictor state.
  logic [31:0] p_train[MaxEntries][MaxWords];
  logic [3:0]  p_toct[MaxEntries];
  int          p_count;
  int          p_pos;
  logic [31:0] p_query[MaxWords];
  logic [3:0]  p_qoct;
  int          p_thr;
  int          p_tol;
  int          p_words;
  bit          gaps_on = 1'b1;
  int          idle_cycles = 0;
  int          items_done;

  // Train and query words drawn near this shared random base make ties common.
  logic [31:0] base_desc[MaxWords];

  function automatic int ones32(logic [31:0] x);
    int c = 0;
    for (int i = 0; i < 32; i++) c += x[i];
    return c;
  endfunction

  function automatic void predict_scan(logic [15:0] qid, int nw);
    int rows[$];
    int best = 511;
    int total = 0;
    int thr;
    int d;
    int diff;
    match_t m;
    thr = (p_thr >= 0) ? p_thr : 2 * nw;
    for (int r = 0; r < p_count; r++) begin
      if (p_tol >= 0) begin
        diff = int'(p_toct[r]) - int'(p_qoct);
        if (diff < 0) diff = -diff;
        if (diff > p_tol) continue;
      end
      d = 0;
      for (int w = 0; w < nw; w++) d += ones32(p_train[r][w] ^ p_query[w]);
      if (total == 0 || d < best) begin
        best = d;
        total = 0;
        rows.delete();
      end
      if (d == best) begin
        if (rows.size() < MaxTies) rows.push_back(r);
        total++;
      end
    end
    if (total == 0 || best > thr) return;
    foreach (rows[k]) begin
      m.qidx = qid;
      m.row = rows[k][9:0];
      m.hdist = best[8:0];
      m.last = (k == rows.size() - 1);
      m.trunc = (total > MaxTies);
      board.note(m);
    end
  endfunction

  function automatic void predict_item(logic [1:0] act, logic [31:0] data, logic [3:0] oct,
                                       logic [15:0] qid);
    int nw;
    int pos;
    bit last;
    nw = (p_words == 0) ? 1 : (p_words > MaxWords ? MaxWords : p_words);
    if (act == ACT_CLEAR) begin
      p_count = 0;
      p_pos = 0;
      return;
    end
    if (act == ACT_NONE) return;
    pos = (p_pos >= nw) ? nw - 1 : p_pos;
    last = (pos + 1 >= nw);
    p_pos = last ? 0 : pos + 1;
    if (act == ACT_TRAIN) begin
      if (p_count < MaxEntries) begin
        p_train[p_count][pos] = data;
        if (pos == 0) p_toct[p_count] = oct;
        if (last) p_count++;
      end
    end else begin
      p_query[pos] = data;
      if (pos == 0) p_qoct = oct;
      if (last) predict_scan(qid, nw);
    end
  endfunction

  task automatic send_item(logic [1:0] act, logic [31:0] data, logic [3:0] oct,
                           logic [15:0] qid);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    word_data <= data;
    octave <= oct;
    query_id <= qid;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(act, data, oct, qid);
    items_done++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [ThrW-1:0] val);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: p_thr = $signed(val);
      REG_TOLERANCE: p_tol = $signed(val[4:0]);
      REG_WORDS:     p_words = val[3:0];
      default: ;
    endcase
  endtask

  // Descriptor near the shared base: few flipped bits, sometimes exact.
  function automatic logic [31:0] near_word(int w);
    logic [31:0] v = base_desc[w];
    int flips = $urandom_range(0, 3);
    for (int i = 0; i < flips; i++) v[$urandom_range(0, 31)] ^= 1'b1;
    return v;
  endfunction

  task automatic send_desc(logic [1:0] act, int nw, bit near, logic [3:0] oct,
                           logic [15:0] qid);
    for (int w = 0; w < nw; w++)
      send_item(act, near ? near_word(w) : $urandom(), oct, qid);
  endtask

  task automatic new_base();
    foreach (base_desc[w]) base_desc[w] = $urandom();
  endtask

  always @(posedge clk) begin
    match_t got;
    if (!rst && match_valid) begin
      got.qidx = query_index;
      got.row = train_row;
      got.hdist = distance;
      got.last = last_match;
      got.trunc = ties_truncated;
      board.check(got);
    end
  end

  // Watchdog on cycles without any accepted item, register write or result.
  always @(posedge clk) begin
    if (rst || match_valid || (start && !busy) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int nw;
    p_count = 0; p_pos = 0; p_qoct = '0;
    p_thr = -1; p_tol = -1; p_words = 8;
    items_done = 0;
    new_base();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of words and data, octave filter, clear, unused action.
    write_reg(REG_WORDS, 10'd1);
    nw = 1;
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);   // empty table
    send_item(ACT_TRAIN, 32'h0000_0000, 4'd0, 16'h0);
    send_item(ACT_TRAIN, 32'hFFFF_FFFF, 4'd15, 16'h0);
    send_item(ACT_TRAIN, 32'h0000_0001, 4'd7, 16'h0);
    send_item(ACT_NONE, 32'hA5A5_A5A5, 4'd3, 16'h1234);
    send_item(ACT_QUERY, 32'h0000_0000, 4'd0, 16'h0000);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
    go_idle();
    write_reg(REG_THRESHOLD, 10'd256);
    write_reg(REG_TOLERANCE, 10'd0);
    send_item(ACT_QUERY, 32'h0000_0003, 4'd7, 16'h00FF);
    go_idle();
    write_reg(REG_TOLERANCE, 10'd15);
    send_item(ACT_QUERY, 32'hF0F0_F0F0, 4'd8, 16'h5555);
    send_item(ACT_CLEAR, 32'h0, 4'd0, 16'h0);
    send_item(ACT_QUERY, 32'h0, 4'd0, 16'hAAAA);            // cleared table
    go_idle();
    // Many identical entries: more ties than can be reported.
    write_reg(REG_TOLERANCE, 10'h01F);
    write_reg(REG_THRESHOLD, 10'd0);
    for (int i = 0; i < 70; i++) send_item(ACT_TRAIN, 32'hDEAD_BEEF, 4'(i), 16'h0);
    send_item(ACT_QUERY, 32'hDEAD_BEEF, 4'd2, 16'h7777);
    go_idle();
    write_reg(REG_THRESHOLD, 10'h3FF);
    send_item(ACT_CLEAR, 32'h0, 4'd0, 16'h0);
    // Mixed actions within one descriptor: last word decides.
    write_reg(REG_WORDS, 10'd8);
    for (int w = 0; w < 8; w++) send_item(ACT_TRAIN, base_desc[w], 4'd1, 16'h0);
    for (int w = 0; w < 8; w++) send_item(ACT_QUERY, base_desc[w], 4'd1, 16'h0041);
    for (int w = 0; w < 7; w++) send_item(ACT_TRAIN, near_word(w), 4'd1, 16'h0);
    send_item(ACT_QUERY, base_desc[7], 4'd1, 16'h0042);
    for (int w = 0; w < 7; w++) send_item(ACT_QUERY, base_desc[w], 4'd1, 16'h0);
    send_item(ACT_TRAIN, base_desc[7], 4'd1, 16'h0);
    for (int w = 0; w < 8; w++) send_item(ACT_QUERY, base_desc[w], 4'd1, 16'h0043);
    go_idle();

    // Random phases across settings; word count 0 and 15 are clamped.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_WORDS, 10'd0);  write_reg(REG_THRESHOLD, 10'h3FF); end
        1: begin write_reg(REG_WORDS, 10'd2);  write_reg(REG_TOLERANCE, 10'd1); end
        2: begin write_reg(REG_WORDS, 10'd15); write_reg(REG_THRESHOLD, 10'd40); end
        3: begin write_reg(REG_WORDS, 10'd3);  write_reg(REG_TOLERANCE, 10'h010); end
        4: begin write_reg(REG_WORDS, 10'd4);  write_reg(REG_THRESHOLD, 10'h200); end
        5: begin write_reg(REG_WORDS, 10'd8);  write_reg(REG_TOLERANCE, 10'd3); end
        6: begin write_reg(REG_WORDS, 10'd1);  write_reg(REG_THRESHOLD, 10'd2); end
        default: begin
          write_reg(REG_WORDS, 10'd5); write_reg(REG_TOLERANCE, 10'h01F);
          write_reg(REG_THRESHOLD, 10'h3FF);
          gaps_on = 1'b0;
        end
      endcase
      nw = (p_words == 0) ? 1 : (p_words > MaxWords ? MaxWords : p_words);
      // Start each phase from a clean table so no unwritten word is ever read.
      send_item(ACT_CLEAR, $urandom(), 4'($urandom()), 16'($urandom()));
      new_base();
      for (int i = 0; i < 40 / nw + 2; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_desc(ACT_TRAIN, nw, $urandom_range(0, 3) != 0,
                                4'($urandom()), 16'($urandom()));
          4, 5, 6: if (p_count > 0)
                     send_desc(ACT_QUERY, nw, $urandom_range(0, 3) != 0,
                               4'($urandom()), 16'($urandom()));
          7: send_item(ACT_NONE, $urandom(), 4'($urandom()), 16'($urandom()));
          // Train words that end in a query word: the query decides, no entry is kept.
          8: if (p_count > 0) begin
               for (int w = 0; w < nw - 1; w++)
                 send_item(ACT_TRAIN, $urandom(), 4'($urandom()), 16'($urandom()));
               send_item(ACT_QUERY, $urandom(), 4'($urandom()), 16'($urandom()));
             end
          default: if ($urandom_range(0, 3) == 0) begin
            send_item(ACT_CLEAR, $urandom(), 4'($urandom()), 16'($urandom()));
          end
        endcase
      end
      // Finish any partial descriptor as a query so no stray position remains.
      while (p_pos != 0)
        send_item(ACT_QUERY, near_word(p_pos), 4'($urandom()), 16'($urandom()));
      go_idle();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
